// ----- rtl/fdda_pkg.sv -----
// ----------------------------------------------------------------------------
// fdda_pkg
// shared widths, register indexes and payload types of the fused dual dot
// product and dual axpy block
// ----------------------------------------------------------------------------
`default_nettype none

package fdda_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 15;
	localparam int ACC_WIDTH  = 48;

	// one complex product term: two products and their sum or difference
	localparam int PROD_WIDTH = 2 * DATA_WIDTH + 1;
	// w scaled up plus two terms plus the rounding constant
	localparam int SUM_WIDTH  = PROD_WIDTH + 2;
	localparam int SHR_WIDTH  = SUM_WIDTH - FRAC_BITS;

	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_ONE_RE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_ONE_IM = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_TWO_RE = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE_TWO_IM = 2'd3;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [ACC_WIDTH-1:0]  acc_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;

	typedef struct packed {
		data_t first_vec_re;
		data_t first_vec_im;
		data_t second_vec_re;
		data_t second_vec_im;
		data_t probe_re;
		data_t probe_im;
		data_t target_re;
		data_t target_im;
		logic  is_last;
	} in_item_t;

	typedef struct packed {
		data_t updated_re;
		data_t updated_im;
		acc_t  dot_one_re;
		acc_t  dot_one_im;
		acc_t  dot_two_re;
		acc_t  dot_two_im;
		logic  done_res;
	} out_item_t;

	typedef struct packed {
		data_t scale_one_re;
		data_t scale_one_im;
		data_t scale_two_re;
		data_t scale_two_im;
	} scale_t;

	// full precision signed product, sign extended to the term width
	function automatic prod_t mul(input data_t a, input data_t b);
		mul = prod_t'(a) * prod_t'(b);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fdda_in_if.sv -----
// ----------------------------------------------------------------------------
// fdda_in_if
// valid/ready channel carrying one vector element item
// ----------------------------------------------------------------------------
`default_nettype none

interface fdda_in_if;
	logic                valid;
	logic                ready;
	fdda_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fdda_out_if.sv -----
// ----------------------------------------------------------------------------
// fdda_out_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
`default_nettype none

interface fdda_out_if;
	logic                valid;
	logic                ready;
	fdda_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fused_dual_dot_dual_axpy.sv -----
// ----------------------------------------------------------------------------
// fused_dual_dot_dual_axpy
// complex w + kappa1*a1 + kappa2*a2 update with two running dot products
// ----------------------------------------------------------------------------
// items enter on the item channel and one result per item leaves on the
// result channel, both valid/ready, a transfer when valid and ready are high.
// kappa1 and kappa2 are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// three register stages: input register, product register (sixteen 16x16
// multipliers feeding the axpy and dot terms), result register where the
// update is rounded and saturated and the dot terms go into the 48-bit
// saturating accumulators. one item per cycle is taken and delivered
// when nothing stalls. each stage advances when the one after it is empty
// or advancing, so a stalled receiver only blocks input once all three
// stages are full.
// on the item marked last the four sums are reported with done_res set and
// the accumulators clear. reset empties the pipeline, clears the
// accumulators and sets both scale factors to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fused_dual_dot_dual_axpy (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire [fdda_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire [fdda_pkg::DATA_WIDTH-1:0]         cfg_data,
	fdda_in_if.sink                                item,
	fdda_out_if.source                             result
);

	typedef struct packed {
		fdda_pkg::prod_t t1r;
		fdda_pkg::prod_t t1i;
		fdda_pkg::prod_t t2r;
		fdda_pkg::prod_t t2i;
		fdda_pkg::prod_t d1r;
		fdda_pkg::prod_t d1i;
		fdda_pkg::prod_t d2r;
		fdda_pkg::prod_t d2i;
		fdda_pkg::data_t wr;
		fdda_pkg::data_t wi;
		logic            last;
	} terms_t;

	fdda_pkg::scale_t    scale_q;
	fdda_pkg::in_item_t  item_s1;
	terms_t              terms_s2;
	terms_t              terms_d;
	fdda_pkg::out_item_t res_q;
	fdda_pkg::out_item_t res_d;
	logic                valid_s1;
	logic                valid_s2;
	logic                res_valid_q;
	logic                en_s1;
	logic                en_s2;
	logic                en_res;
	fdda_pkg::acc_t      acc_one_re_q;
	fdda_pkg::acc_t      acc_one_im_q;
	fdda_pkg::acc_t      acc_two_re_q;
	fdda_pkg::acc_t      acc_two_im_q;
	fdda_pkg::acc_t      sum_one_re;
	fdda_pkg::acc_t      sum_one_im;
	fdda_pkg::acc_t      sum_two_re;
	fdda_pkg::acc_t      sum_two_im;

	function automatic fdda_pkg::data_t round_update(input fdda_pkg::data_t w,
			input fdda_pkg::prod_t ta, input fdda_pkg::prod_t tb);
		logic signed [fdda_pkg::SUM_WIDTH-1:0] s;
		logic signed [fdda_pkg::SHR_WIDTH-1:0] sh;
		s = (fdda_pkg::SUM_WIDTH'(w) <<< fdda_pkg::FRAC_BITS)
			+ fdda_pkg::SUM_WIDTH'(ta) + fdda_pkg::SUM_WIDTH'(tb)
			+ (fdda_pkg::SUM_WIDTH'(1) <<< (fdda_pkg::FRAC_BITS - 1));
		sh = fdda_pkg::SHR_WIDTH'(s >>> fdda_pkg::FRAC_BITS);
		// saturate when the bits above the result width are not all sign
		if (sh[fdda_pkg::SHR_WIDTH-1] == 1'b0
				&& sh[fdda_pkg::SHR_WIDTH-2:fdda_pkg::DATA_WIDTH-1] != '0) begin
			round_update = {1'b0, {(fdda_pkg::DATA_WIDTH-1){1'b1}}};
		end else if (sh[fdda_pkg::SHR_WIDTH-1] == 1'b1
				&& sh[fdda_pkg::SHR_WIDTH-2:fdda_pkg::DATA_WIDTH-1] != '1) begin
			round_update = {1'b1, {(fdda_pkg::DATA_WIDTH-1){1'b0}}};
		end else begin
			round_update = sh[fdda_pkg::DATA_WIDTH-1:0];
		end
	endfunction

	function automatic fdda_pkg::acc_t acc_add(input fdda_pkg::acc_t acc,
			input fdda_pkg::prod_t t);
		logic signed [fdda_pkg::ACC_WIDTH:0] s;
		s = (fdda_pkg::ACC_WIDTH+1)'(acc) + (fdda_pkg::ACC_WIDTH+1)'(t);
		if (s[fdda_pkg::ACC_WIDTH] != s[fdda_pkg::ACC_WIDTH-1]) begin
			acc_add = s[fdda_pkg::ACC_WIDTH]
				? {1'b1, {(fdda_pkg::ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(fdda_pkg::ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_add = s[fdda_pkg::ACC_WIDTH-1:0];
		end
	endfunction

	// a stage loads when the next one is empty or moving on
	assign en_res     = !res_valid_q || result.ready;
	assign en_s2      = !valid_s2 || en_res;
	assign en_s1      = !valid_s1 || en_s2;
	assign item.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdda_pkg::REG_SCALE_ONE_RE: scale_q.scale_one_re <= cfg_data;
				fdda_pkg::REG_SCALE_ONE_IM: scale_q.scale_one_im <= cfg_data;
				fdda_pkg::REG_SCALE_TWO_RE: scale_q.scale_two_re <= cfg_data;
				fdda_pkg::REG_SCALE_TWO_IM: scale_q.scale_two_im <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_res) begin
				res_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && item.valid) begin
			item_s1 <= item.data;
		end
		if (en_s2 && valid_s1) begin
			terms_s2 <= terms_d;
		end
		if (en_res && valid_s2) begin
			res_q <= res_d;
		end
	end

	// products: axpy terms kappa*a, dot terms conj(a)*x
	always_comb begin
		terms_d.t1r = fdda_pkg::mul(scale_q.scale_one_re, item_s1.first_vec_re)
			- fdda_pkg::mul(scale_q.scale_one_im, item_s1.first_vec_im);
		terms_d.t1i = fdda_pkg::mul(scale_q.scale_one_re, item_s1.first_vec_im)
			+ fdda_pkg::mul(scale_q.scale_one_im, item_s1.first_vec_re);
		terms_d.t2r = fdda_pkg::mul(scale_q.scale_two_re, item_s1.second_vec_re)
			- fdda_pkg::mul(scale_q.scale_two_im, item_s1.second_vec_im);
		terms_d.t2i = fdda_pkg::mul(scale_q.scale_two_re, item_s1.second_vec_im)
			+ fdda_pkg::mul(scale_q.scale_two_im, item_s1.second_vec_re);
		terms_d.d1r = fdda_pkg::mul(item_s1.first_vec_re, item_s1.probe_re)
			+ fdda_pkg::mul(item_s1.first_vec_im, item_s1.probe_im);
		terms_d.d1i = fdda_pkg::mul(item_s1.first_vec_re, item_s1.probe_im)
			- fdda_pkg::mul(item_s1.first_vec_im, item_s1.probe_re);
		terms_d.d2r = fdda_pkg::mul(item_s1.second_vec_re, item_s1.probe_re)
			+ fdda_pkg::mul(item_s1.second_vec_im, item_s1.probe_im);
		terms_d.d2i = fdda_pkg::mul(item_s1.second_vec_re, item_s1.probe_im)
			- fdda_pkg::mul(item_s1.second_vec_im, item_s1.probe_re);
		terms_d.wr   = item_s1.target_re;
		terms_d.wi   = item_s1.target_im;
		terms_d.last = item_s1.is_last;
	end

	assign sum_one_re = acc_add(acc_one_re_q, terms_s2.d1r);
	assign sum_one_im = acc_add(acc_one_im_q, terms_s2.d1i);
	assign sum_two_re = acc_add(acc_two_re_q, terms_s2.d2r);
	assign sum_two_im = acc_add(acc_two_im_q, terms_s2.d2i);

	always_comb begin
		res_d.updated_re = round_update(terms_s2.wr, terms_s2.t1r, terms_s2.t2r);
		res_d.updated_im = round_update(terms_s2.wi, terms_s2.t1i, terms_s2.t2i);
		res_d.dot_one_re = terms_s2.last ? sum_one_re : '0;
		res_d.dot_one_im = terms_s2.last ? sum_one_im : '0;
		res_d.dot_two_re = terms_s2.last ? sum_two_re : '0;
		res_d.dot_two_im = terms_s2.last ? sum_two_im : '0;
		res_d.done_res   = terms_s2.last;
	end

	// accumulators clear once the last element's sums are reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_one_re_q <= '0;
			acc_one_im_q <= '0;
			acc_two_re_q <= '0;
			acc_two_im_q <= '0;
		end else if (en_res && valid_s2) begin
			if (terms_s2.last) begin
				acc_one_re_q <= '0;
				acc_one_im_q <= '0;
				acc_two_re_q <= '0;
				acc_two_im_q <= '0;
			end else begin
				acc_one_re_q <= sum_one_re;
				acc_one_im_q <= sum_one_im;
				acc_two_re_q <= sum_two_re;
				acc_two_im_q <= sum_two_im;
			end
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fused dual dot product and dual axpy block
// ----------------------------------------------------------------------------
// streams vector elements through the item channel under random idling on
// both sides, predicts each updated element and the two running dot products
// in a bit-true model of its own, and compares every result field by field.
// kappa1 and kappa2 are rewritten between phases while the block is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic [fdda_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	fdda_pkg::data_t                      cfg_data = '0;

	fdda_in_if  item_ch ();
	fdda_out_if result_ch ();

	fused_dual_dot_dual_axpy u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	fdda_pkg::in_item_t  pending_elements[$];
	fdda_pkg::out_item_t expected_results[$];

	// model copy of the scale factors and the four dot product sums
	fdda_pkg::scale_t model_scale;
	longint sum_one_re, sum_one_im, sum_two_re, sum_two_im;

	int send_idle_pct = 37;
	int recv_idle_pct = 86;
	int hold_requests = 0;
	int holds_started;
	int hold_left;
	int mismatches = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint saturate(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// round half up then clamp to the data width
	function automatic longint rounded_update(input longint w, input longint t1,
			input longint t2);
		longint s;
		s = (w <<< fdda_pkg::FRAC_BITS) + t1 + t2
			+ (longint'(1) <<< (fdda_pkg::FRAC_BITS - 1));
		return saturate(s >>> fdda_pkg::FRAC_BITS, fdda_pkg::DATA_WIDTH);
	endfunction

	function automatic fdda_pkg::out_item_t update_and_accumulate(
			input fdda_pkg::in_item_t e);
		fdda_pkg::out_item_t r;
		longint    a1r, a1i, a2r, a2i, xr, xi;
		longint    k1r, k1i, k2r, k2i;
		a1r = e.first_vec_re;
		a1i = e.first_vec_im;
		a2r = e.second_vec_re;
		a2i = e.second_vec_im;
		xr  = e.probe_re;
		xi  = e.probe_im;
		k1r = model_scale.scale_one_re;
		k1i = model_scale.scale_one_im;
		k2r = model_scale.scale_two_re;
		k2i = model_scale.scale_two_im;
		r = '0;
		r.updated_re = fdda_pkg::data_t'(rounded_update(e.target_re,
			k1r * a1r - k1i * a1i, k2r * a2r - k2i * a2i));
		r.updated_im = fdda_pkg::data_t'(rounded_update(e.target_im,
			k1r * a1i + k1i * a1r, k2r * a2i + k2i * a2r));
		// conjugate of the column times the probe
		sum_one_re = saturate(sum_one_re + a1r * xr + a1i * xi, fdda_pkg::ACC_WIDTH);
		sum_one_im = saturate(sum_one_im + a1r * xi - a1i * xr, fdda_pkg::ACC_WIDTH);
		sum_two_re = saturate(sum_two_re + a2r * xr + a2i * xi, fdda_pkg::ACC_WIDTH);
		sum_two_im = saturate(sum_two_im + a2r * xi - a2i * xr, fdda_pkg::ACC_WIDTH);
		if (e.is_last) begin
			r.dot_one_re = fdda_pkg::acc_t'(sum_one_re);
			r.dot_one_im = fdda_pkg::acc_t'(sum_one_im);
			r.dot_two_re = fdda_pkg::acc_t'(sum_two_re);
			r.dot_two_im = fdda_pkg::acc_t'(sum_two_im);
			r.done_res = 1'b1;
			sum_one_re = 0;
			sum_one_im = 0;
			sum_two_re = 0;
			sum_two_im = 0;
		end
		return r;
	endfunction

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// driver: next element goes out once the current one has transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_ch.valid <= 1'b1;
				item_ch.data <= pending_elements.pop_front();
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, or a long hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left <= 0;
			holds_started <= 0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_started != hold_requests) begin
			result_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_started <= holds_started + 1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on each element transfer, check on each result transfer
	always @(posedge clk) begin
		fdda_pkg::out_item_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t mismatch: result with none expected, actual %h",
						$time, result_ch.data);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("updated_re", want.updated_re, result_ch.data.updated_re);
					check_field("updated_im", want.updated_im, result_ch.data.updated_im);
					check_field("dot_one_re", want.dot_one_re, result_ch.data.dot_one_re);
					check_field("dot_one_im", want.dot_one_im, result_ch.data.dot_one_im);
					check_field("dot_two_re", want.dot_two_re, result_ch.data.dot_two_re);
					check_field("dot_two_im", want.dot_two_im, result_ch.data.dot_two_im);
					check_field("done_res", want.done_res, result_ch.data.done_res);
				end
			end
			if (item_ch.valid && item_ch.ready)
				expected_results.push_back(update_and_accumulate(item_ch.data));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic fdda_pkg::data_t pick_data();
		case ($urandom_range(15))
			0: return fdda_pkg::data_t'(-32768);
			1: return fdda_pkg::data_t'(32767);
			2: return fdda_pkg::data_t'(0);
			3: return fdda_pkg::data_t'(-1);
			default: return fdda_pkg::data_t'($urandom);
		endcase
	endfunction

	task automatic write_scale(input logic [fdda_pkg::CFG_INDEX_WIDTH-1:0] reg_index,
			input fdda_pkg::data_t value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (reg_index)
			fdda_pkg::REG_SCALE_ONE_RE: model_scale.scale_one_re = value;
			fdda_pkg::REG_SCALE_ONE_IM: model_scale.scale_one_im = value;
			fdda_pkg::REG_SCALE_TWO_RE: model_scale.scale_two_re = value;
			fdda_pkg::REG_SCALE_TWO_IM: model_scale.scale_two_im = value;
		endcase
	endtask

	task automatic set_scales(input fdda_pkg::data_t k1r, k1i, k2r, k2i);
		write_scale(fdda_pkg::REG_SCALE_ONE_RE, k1r);
		write_scale(fdda_pkg::REG_SCALE_ONE_IM, k1i);
		write_scale(fdda_pkg::REG_SCALE_TWO_RE, k2r);
		write_scale(fdda_pkg::REG_SCALE_TWO_IM, k2i);
	endtask

	task automatic queue_element(input fdda_pkg::data_t a1r, a1i, a2r, a2i, xr, xi, wr, wi,
			input logic last);
		fdda_pkg::in_item_t e;
		e.first_vec_re = a1r;
		e.first_vec_im = a1i;
		e.second_vec_re = a2r;
		e.second_vec_im = a2i;
		e.probe_re = xr;
		e.probe_im = xi;
		e.target_re = wr;
		e.target_im = wi;
		e.is_last = last;
		pending_elements.push_back(e);
	endtask

	task automatic queue_random_vectors(input int count);
		int queued;
		int length;
		bit real_only;
		queued = 0;
		while (queued < count) begin
			length = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			// zero imaginary parts give the real-valued form
			real_only = ($urandom_range(5) == 0);
			for (int i = 0; i < length; i++)
				queue_element(pick_data(), real_only ? fdda_pkg::data_t'(0) : pick_data(),
					pick_data(), real_only ? fdda_pkg::data_t'(0) : pick_data(),
					pick_data(), real_only ? fdda_pkg::data_t'(0) : pick_data(),
					pick_data(), real_only ? fdda_pkg::data_t'(0) : pick_data(),
					i == length - 1);
			queued += length;
		end
	endtask

	task automatic wait_for_drain();
		while (pending_elements.size() != 0 || item_ch.valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		model_scale = '0;
		sum_one_re = 0;
		sum_one_im = 0;
		sum_two_re = 0;
		sum_two_im = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// half-way rounding cases, positive and negative
		set_scales(16384, 16384, 0, 0);
		queue_element(1, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		queue_element(-1, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		queue_element(1, 0, 0, 0, 0, 0, -1, -1, 1'b1);
		wait_for_drain();

		set_scales(-32768, -32768, -32768, -32768);
		queue_element(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
		queue_element(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
		queue_element(32767, 32767, 32767, 32767, -32768, -32768, -32768, 32767, 1'b0);
		queue_element(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		queue_element(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1'b1);
		queue_element(pick_data(), pick_data(), pick_data(), pick_data(),
			pick_data(), pick_data(), pick_data(), pick_data(), 1'b0);
		queue_element(pick_data(), pick_data(), pick_data(), pick_data(),
			pick_data(), pick_data(), pick_data(), pick_data(), 1'b0);
		// pause mid-vector: sums must survive an idle spell and a rewrite
		wait_for_drain();
		write_scale(fdda_pkg::REG_SCALE_TWO_RE, 32767);
		queue_element(pick_data(), pick_data(), pick_data(), pick_data(),
			pick_data(), pick_data(), pick_data(), pick_data(), 1'b1);
		wait_for_drain();

		// update saturation both ways, and the real-valued form
		set_scales(32767, 32767, 32767, 32767);
		queue_element(32767, -32768, 32767, -32768, 1, 2, 32767, 32767, 1'b0);
		queue_element(-32768, 32767, -32768, 32767, 3, 4, -32768, -32768, 1'b0);
		queue_element(12345, 0, -20000, 0, 30000, 0, 1000, 0, 1'b0);
		queue_element(-7, 0, 32767, 0, -32768, 0, -1000, 0, 1'b1);
		queue_element(32767, 32767, 32767, 32767, 5, 6, 0, 32767, 1'b0);
		queue_element(-32768, -32768, -32768, -32768, 7, 8, 0, -32768, 1'b1);
		wait_for_drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_scales(pick_data(), pick_data(), pick_data(), pick_data());
			// receiver holds off while the sender keeps offering
			if (phase == 2)
				hold_requests++;
			queue_random_vectors(200);
			wait_for_drain();
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/fdda_pkg.sv
rtl/fdda_in_if.sv
rtl/fdda_out_if.sv
rtl/fused_dual_dot_dual_axpy.sv
tb/testbench.sv
